@@ hdl/archive_byte_stream_decipher_assert.svh @@
// Assertion macros of the checker of the byte stream decipher
`ifndef ARCHIVE_BYTE_STREAM_DECIPHER_ASSERT_SVH
`define ARCHIVE_BYTE_STREAM_DECIPHER_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define ABS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abs assertion failed");

// Next-cycle implication, off while reset is high
`define ABS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abs assertion failed");

`endif

@@ hdl/abs_pkg.sv @@
// Types, register indexes and helper functions of the byte stream decipher
package abs_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [3:0] IdxBReload = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NAME_KEY = 2'd0,
    REG_SIZE_KEY = 2'd1,
    REG_START_MIX = 2'd2,
    REG_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] name_key;
    logic [31:0] size_key;
    logic [6:0]  start_mix;
    logic        enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0] idx_a;
    logic [3:0] idx_b;
    logic       swap;
    logic [6:0] mix;
  } ks_t;

  // Pick byte idx (mod 4) of a key word, little-endian
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    return key[{idx, 3'b000} +: 8];
  endfunction

  // v mod 7 by reciprocal estimate (36/256) and one correction
  function automatic logic [2:0] mod7(input logic [6:0] v);
    logic [12:0] p;
    logic [4:0]  q;
    logic [7:0]  prod;
    logic [6:0]  r;
    p = 13'(v) * 13'd36;
    q = p[12:8];
    prod = 8'(q) * 8'd7;
    r = 7'(8'(v) - prod);
    if (r >= 7'd7) begin
      r = r - 7'd7;
    end
    return r[2:0];
  endfunction

  // v mod 12: low two bits pass, (v >> 2) mod 3 by estimate (10/32) and correction
  function automatic logic [3:0] mod12(input logic [6:0] v);
    logic [4:0] u;
    logic [8:0] p;
    logic [3:0] q;
    logic [4:0] prod;
    logic [4:0] r;
    u = v[6:2];
    p = 9'(u) * 9'd10;
    q = p[8:5];
    prod = 5'(5'(q) * 5'd3);
    r = u - prod;
    if (r >= 5'd3) begin
      r = r - 5'd3;
    end
    return {r[1:0], v[1:0]};
  endfunction

endpackage

@@ hdl/archive_byte_stream_decipher.sv @@
// Top level of the archive byte stream decipher
//
//   port group   dir  payload
//   s_*          in   tdata[7:0] cipher_byte, tuser[0] restart
//   m_*          out  tdata[7:0] plain_byte
//   cfg_*        in   write enable, 2-bit register index, 32-bit data
//
// One word per cycle while the output is taken: an input register feeds the keystream update
// and byte transform, which load the result register in the same cycle.
// A taken word passes the input register and then the result register to the output.
// rst is synchronous: keys, enable and start mix clear, indices go to A=0, B=8.
// A stalled output holds its word; the input register still takes one more.
module archive_byte_stream_decipher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] cipher_byte
  input  logic                        s_tuser,  // [0] restart
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,  // [7:0] plain_byte
  input  logic                        cfg_wr_en,
  input  logic [abs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import abs_pkg::*;

  cfg_t       cfg;
  ks_t        cur;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       out_free;
  logic       advance;
  logic [7:0] plain_byte;

  assign out_free = !m_tvalid || m_tready;
  assign advance = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  abs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  abs_keystream u_ks (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (in_restart),
    .advance (advance),
    .cur     (cur)
  );

  abs_byte_xform u_xf (
    .cfg         (cfg),
    .cur         (cur),
    .cipher_byte (in_byte),
    .plain_byte  (plain_byte)
  );

  // Input register: take a word whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= plain_byte;
    end
  end

endmodule

@@ hdl/abs_cfg_regs.sv @@
// Configuration register file of the byte stream decipher
module abs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [abs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [31:0]                      cfg_data,
  output abs_pkg::cfg_t                    cfg
);
  import abs_pkg::*;

  cfg_t regs;

  // Write one register per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_NAME_KEY:  regs.name_key <= cfg_data;
        REG_SIZE_KEY:  regs.size_key <= cfg_data;
        REG_START_MIX: regs.start_mix <= cfg_data[6:0];
        REG_ENABLE:    regs.enable <= cfg_data[0];
        default:       regs <= regs;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ hdl/abs_keystream.sv @@
// Keystream state: indices, swap flag and mix value with their update rules
module abs_keystream (
  input  logic          clk,
  input  logic          rst,
  input  abs_pkg::cfg_t cfg,
  input  logic          restart,
  input  logic          advance,
  output abs_pkg::ks_t  cur
);
  import abs_pkg::*;

  ks_t        state;
  ks_t        state_next;
  ks_t        upd;
  logic [4:0] a1;
  logic [4:0] b1;
  logic [6:0] mix2;

  // Apply restart ahead of the word
  always_comb begin
    if (restart) begin
      cur.idx_a = '0;
      cur.idx_b = IdxBReload;
      cur.swap = 1'b0;
      cur.mix = cfg.start_mix;
    end else begin
      cur = state;
    end
  end

  // Advance indices and apply the table rules
  always_comb begin
    a1 = 5'(cur.idx_a) + 5'd1;
    b1 = 5'(cur.idx_b) + 5'd1;
    mix2 = cur.mix + 7'd2;
    upd = cur;
    if (!a1[4]) begin
      upd.idx_a = a1[3:0];
      if (b1 > 5'd12) begin
        upd.idx_b = '0;
        upd.swap = ~cur.swap;
      end else begin
        upd.idx_b = b1[3:0];
      end
    end else if (b1 <= 5'd8) begin
      upd.idx_a = '0;
      upd.idx_b = b1[3:0];
      upd.swap = ~cur.swap;
    end else begin
      upd.mix = mix2;
      if (cur.swap) begin
        upd.swap = 1'b0;
        upd.idx_a = 4'(mod7(mix2));
        upd.idx_b = mod12(mix2) + 4'd2;
      end else begin
        upd.swap = 1'b1;
        upd.idx_a = mod12(mix2) + 4'd3;
        upd.idx_b = 4'(mod7(mix2));
      end
    end
  end

  // Hold state when disabled, but keep a restart
  always_comb begin
    state_next = state;
    if (advance) begin
      state_next = cfg.enable ? upd : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.idx_a <= '0;
      state.idx_b <= IdxBReload;
      state.swap <= 1'b0;
      state.mix <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/abs_byte_xform.sv @@
// Byte transform: mix and key B XOR, optional nibble swap, key A XOR; pass-through when disabled
module abs_byte_xform (
  input  abs_pkg::cfg_t cfg,
  input  abs_pkg::ks_t  cur,
  input  logic [7:0]    cipher_byte,
  output logic [7:0]    plain_byte
);
  import abs_pkg::*;

  logic [7:0] t0;
  logic [7:0] t1;

  always_comb begin
    t0 = cipher_byte ^ {1'b0, cur.mix} ^ key_byte(cfg.size_key, cur.idx_b[1:0]);
    t1 = cur.swap ? {t0[3:0], t0[7:4]} : t0;
    plain_byte = cfg.enable ? (t1 ^ key_byte(cfg.name_key, cur.idx_a[1:0])) : cipher_byte;
  end

endmodule

@@ hdl/abs_checker.sv @@
// Port-level checker of the byte stream decipher and its bind
`include "archive_byte_stream_decipher_assert.svh"

module abs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Hold a stalled result word
  `ABS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Input side stalls only behind a stalled result
  `ABS_ASSERT_IMP(a_stall_cause, clk, rst, !s_tready, m_tvalid && !m_tready)

  // An accepted word shows as valid output when the sink is ready while it sits in the input register
  `ABS_ASSERT_NEXT(a_latency, clk, rst, (s_tvalid && s_tready) ##1 m_tready, m_tvalid)

endmodule

bind archive_byte_stream_decipher abs_checker u_abs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the archive byte stream decipher
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import abs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic       restart;
    logic [7:0] cipher;
  } cipher_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_NAME_KEY;
  logic [31:0] cfg_data = 32'h0;

  // Keystream state and register copies of the predictor
  logic [4:0]  ks_a = 5'd0;
  logic [3:0]  ks_b = IdxBReload;
  logic        ks_swap = 1'b0;
  logic [6:0]  ks_mix = 7'd0;
  logic [31:0] cf_name = 32'h0;
  logic [31:0] cf_size = 32'h0;
  logic [6:0]  cf_mix = 7'd0;
  logic        cf_en = 1'b0;

  cipher_word_t cipher_pending_q[$];
  logic [7:0]   plain_expected_q[$];
  cipher_word_t next_word;
  logic [7:0]   plain_want;
  logic         in_taken = 1'b0;

  int src_idle_pct = 23;
  int snk_idle_pct = 52;
  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_restarts = 0;
  int n_errors = 0;
  int n_settings = 0;
  int stall_cycles = 0;

  archive_byte_stream_decipher DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] cipher_byte
    .s_tuser   (s_tuser),   // [0] restart
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] plain_byte
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decipher one byte and, when enabled, advance the keystream state
  function automatic logic [7:0] decipher_byte(input logic [7:0] c, input logic restart);
    logic [7:0] t;
    logic [4:0] a;
    logic [4:0] b;
    if (restart) begin
      ks_a = 5'd0;
      ks_b = IdxBReload;
      ks_swap = 1'b0;
      ks_mix = cf_mix;
    end
    if (!cf_en) begin
      return c;
    end
    a = {1'b0, ks_a[3:0]};
    b = {1'b0, ks_b};
    t = c ^ {1'b0, ks_mix} ^ cf_size[{b[1:0], 3'b000} +: 8];
    if (ks_swap) begin
      t = {t[3:0], t[7:4]};
    end
    t = t ^ cf_name[{a[1:0], 3'b000} +: 8];
    a = a + 5'd1;
    b = b + 5'd1;
    if (a <= 5'd15) begin
      if (b > 5'd12) begin
        b = 5'd0;
        ks_swap = !ks_swap;
      end
    end else if (b <= 5'd8) begin
      a = 5'd0;
      ks_swap = !ks_swap;
    end else begin
      ks_mix = ks_mix + 7'd2;
      if (ks_swap) begin
        ks_swap = 1'b0;
        a = 5'(ks_mix % 7);
        b = 5'(ks_mix % 12 + 2);
      end else begin
        ks_swap = 1'b1;
        a = 5'(ks_mix % 12 + 3);
        b = 5'(ks_mix % 7);
      end
    end
    ks_a = a;
    ks_b = b[3:0];
    return t;
  endfunction

  // Drive input words and receiver backpressure on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (cipher_pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_word = cipher_pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_word.cipher;
          s_tuser  <= next_word.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Predict on input accept, check on output accept, watch for a hang
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        plain_expected_q.push_back(decipher_byte(s_tdata, s_tuser));
        n_accepted++;
        if (s_tuser) begin
          n_restarts++;
        end
      end
      if (m_tvalid && m_tready) begin
        n_results++;
        if (plain_expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX) begin
            $display("unexpected output word plain_byte=%h", m_tdata);
          end
        end else begin
          plain_want = plain_expected_q.pop_front();
          if (m_tdata !== plain_want) begin
            n_errors++;
            if (n_errors <= REPORT_MAX) begin
              $display("word %0d plain_byte: expected %h, got %h", n_results, plain_want,
                       m_tdata);
            end
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no word moved for %0d cycles", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Write one register; the block is idle whenever this is called
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_NAME_KEY:  cf_name = val;
      REG_SIZE_KEY:  cf_size = val;
      REG_START_MIX: cf_mix = val[6:0];
      REG_ENABLE:    cf_en = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_keys(input logic [31:0] name_key, input logic [31:0] size_key,
                          input logic [6:0] mix, input logic en);
    write_reg(REG_NAME_KEY, name_key);
    write_reg(REG_SIZE_KEY, size_key);
    write_reg(REG_START_MIX, {25'h0, mix});
    write_reg(REG_ENABLE, {31'h0, en});
    n_settings++;
  endtask

  task automatic send_byte(input logic [7:0] c, input logic restart);
    cipher_word_t w;
    w.cipher = c;
    w.restart = restart;
    cipher_pending_q.push_back(w);
    n_pushed++;
  endtask

  // Hold until every queued word went in and every result came out
  task automatic drain();
    while (n_accepted != n_pushed || n_results != n_accepted) begin
      @(negedge clk);
    end
  endtask

  // Random bytes with restarts at the given percentage; rare restarts give long runs through the index rules
  task automatic random_run(input int count, input int restart_pct, input bit first_restart);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(255)),
                (i == 0 && first_restart) || ($urandom_range(99) < restart_pct));
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pass-through after reset, restart while disabled
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    drain();

    // Deciphering with distinct key bytes, extremes of the byte
    set_keys(32'h0403_0201, 32'h80C0_E0F0, 7'h55, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_byte(8'(8'h11 * i), 1'b0);
    end
    drain();

    // New start mix holds off until the next restart
    write_reg(REG_START_MIX, 32'h7F);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    drain();

    // Disabled bytes pass and leave the keystream where it was
    write_reg(REG_ENABLE, 32'h0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b0);
    drain();
    write_reg(REG_ENABLE, 32'h1);
    send_byte(8'h18, 1'b0);
    send_byte(8'hE7, 1'b0);
    drain();

    // Random part, sender idles less than receiver
    set_keys(32'hFFFF_FFFF, 32'h0000_0000, 7'h7F, 1'b1);
    random_run(140, 2, 1'b1);
    set_keys(32'h0000_0000, 32'hFFFF_FFFF, 7'h00, 1'b1);
    random_run(140, 2, 1'b1);

    // Receiver idles less than sender
    src_idle_pct = 52;
    snk_idle_pct = 23;
    set_keys($urandom, $urandom, 7'($urandom_range(127)), 1'b1);
    random_run(140, 2, 1'b1);
    set_keys($urandom, $urandom, 7'($urandom_range(127)), 1'b0);
    random_run(70, 20, 1'b0);

    // No idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_keys($urandom, $urandom, 7'($urandom_range(127)), 1'b1);
    random_run(100, 30, 1'b1);
    set_keys($urandom, $urandom, 7'($urandom_range(127)), 1'b1);
    random_run(220, 1, 1'b1);

    repeat (8) @(negedge clk);
    if (plain_expected_q.size() != 0) begin
      $display("%0d expected words never arrived", plain_expected_q.size());
      n_errors += plain_expected_q.size();
    end
    $display("ran %0d cipher bytes (%0d with restart) over %0d key settings",
             n_accepted, n_restarts, n_settings);
    $display("checked %0d plain bytes, %0d mismatches", n_results, n_errors);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
